FILE: rtl/core/masked_hamming_row_scorer_defines.svh
// ----------------------------------------------------------------------------
// Masked Hamming row scorer assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MASKED_HAMMING_ROW_SCORER_DEFINES_SVH
`define MASKED_HAMMING_ROW_SCORER_DEFINES_SVH

`ifndef SYNTH
// property holds in every cycle
`define MHRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent holds in the cycle after antecedent
`define MHRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MHRS_ASSERT(label, clk, rst, prop, msg)
`define MHRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/core/mhrs_pkg.sv
// ----------------------------------------------------------------------------
// Masked Hamming row scorer package
// Widths, request kinds and the popcount/saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mhrs_pkg;

   localparam int ROW_WORDS   = 16;
   localparam int INDEX_W     = 4;
   localparam int QUERY_DEPTH = 16;
   localparam int WORD_W      = 64;
   localparam int PC_W        = 7;
   localparam int COUNT_W     = 11;
   localparam int SCORE_W     = 13;
   localparam int DIFF_W      = 15;
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 16;

   localparam logic [INDEX_W-1:0] LAST_INDEX  = INDEX_W'(ROW_WORDS - 1);
   localparam logic [INDEX_W-1:0] FIRST_INDEX = '0;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

   localparam logic signed [DIFF_W-1:0] SCORE_MIN = -DIFF_W'(2048);
   localparam logic signed [DIFF_W-1:0] SCORE_MAX = DIFF_W'(2048);

   typedef enum logic [0:0] {
      KIND_QUERY = 1'b0,
      KIND_ROW   = 1'b1
   } kind_type;

   function automatic logic [PC_W-1:0] popcount64(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] v;
      v = x - ((x >> 1) & 64'h5555_5555_5555_5555);
      v = (v & 64'h3333_3333_3333_3333) + ((v >> 2) & 64'h3333_3333_3333_3333);
      v = (v + (v >> 4)) & 64'h0f0f_0f0f_0f0f_0f0f;
      v = v + (v >> 8);
      v = v + (v >> 16);
      v = v + (v >> 32);
      return v[PC_W-1:0];
   endfunction

   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] acc,
                                                  input logic [PC_W-1:0] add);
      logic [COUNT_W:0] sum;
      sum = {1'b0, acc} + (COUNT_W + 1)'(add);
      return sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/masked_hamming_row_scorer.sv
// ----------------------------------------------------------------------------
// Masked Hamming row scorer
// Stores a ternary query (sign and care mask) and scores row words against
// it, giving 2*mask_count - 4*mismatches clamped to +-2048 on each row's last word.
// ----------------------------------------------------------------------------
// A row's score goes through the s1, s2 and score registers after its last word
// is accepted. Throughput: one request per cycle while rsp is not stalled; set by the
// single popcount and accumulate stage that reads the query register file.
// Reset: clears valid flags, mask count and mismatch total; the query store
// holds no defined value until loaded.
`default_nettype none

`include "masked_hamming_row_scorer_defines.svh"

module masked_hamming_row_scorer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // word_index[3:0], data_word[67:4], mask_word[131:68], zero pad
   input  wire logic [mhrs_pkg::REQ_TDATA_W-1:0] req_tdata,
   // kind[0]
   input  wire logic                             req_tuser,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // score[12:0], zero pad
   output      logic [mhrs_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import mhrs_pkg::*;

   logic [WORD_W-1:0]  query_sign_ff [QUERY_DEPTH];
   logic [WORD_W-1:0]  query_mask_ff [QUERY_DEPTH];

   logic               s1_valid_ff, s1_valid_in;
   kind_type           s1_kind_ff;
   logic [INDEX_W-1:0] s1_index_ff;
   logic [WORD_W-1:0]  s1_data_ff;
   logic [WORD_W-1:0]  s1_mask_ff;

   logic [COUNT_W-1:0] mask_count_ff, mask_count_in;
   logic [COUNT_W-1:0] mismatch_ff, mismatch_in;

   logic               s2_valid_ff, s2_valid_in;
   logic [COUNT_W-1:0] s2_mask_count_ff;
   logic [COUNT_W-1:0] s2_mismatch_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0] score_ff, score_in;

   logic               req_accept;
   logic               s1_emit, s1_advance, s1_is_row, s1_query_write;
   logic               s2_load, s2_advance, out_ready;
   logic [PC_W-1:0]    mask_pc, miss_pc;
   logic [COUNT_W-1:0] miss_base;
   logic signed [DIFF_W-1:0] diff;

   // handshake
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign s2_advance = s2_valid_ff && out_ready;
   assign s1_is_row  = (s1_kind_ff == KIND_ROW);
   assign s1_emit    = s1_is_row && (s1_index_ff == LAST_INDEX);
   assign s1_advance = s1_valid_ff && (!s1_emit || !s2_valid_ff || out_ready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;
   assign s2_load    = s1_advance && s1_emit;
   assign s1_query_write = s1_advance && !s1_is_row;

   // scoring stage
   always_comb begin
      mask_pc   = popcount64(s1_mask_ff);
      miss_pc   = popcount64((s1_data_ff ^ query_sign_ff[s1_index_ff])
                             & query_mask_ff[s1_index_ff]);
      miss_base = (s1_index_ff == FIRST_INDEX) ? '0 : mismatch_ff;

      mask_count_in = mask_count_ff;
      mismatch_in   = mismatch_ff;
      if (s1_advance) begin
         if (s1_is_row) begin
            mismatch_in = sat_add(miss_base, miss_pc);
         end else if (s1_index_ff == FIRST_INDEX) begin
            mask_count_in = COUNT_W'(mask_pc);
         end else begin
            mask_count_in = sat_add(mask_count_ff, mask_pc);
         end
      end

      s1_valid_in  = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s2_load ? 1'b1 : (s2_advance ? 1'b0 : s2_valid_ff);
      rsp_valid_in = s2_advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // score and clamp
   always_comb begin
      diff = $signed({3'b000, s2_mask_count_ff, 1'b0})
           - $signed({2'b00, s2_mismatch_ff, 2'b00});
      if (diff < SCORE_MIN) begin
         score_in = SCORE_MIN[SCORE_W-1:0];
      end else if (diff > SCORE_MAX) begin
         score_in = SCORE_MAX[SCORE_W-1:0];
      end else begin
         score_in = diff[SCORE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mask_count_ff <= '0;
         mismatch_ff   <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         mask_count_ff <= mask_count_in;
         mismatch_ff   <= mismatch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff  <= kind_type'(req_tuser);
         s1_index_ff <= req_tdata[INDEX_W-1:0];
         s1_data_ff  <= req_tdata[INDEX_W +: WORD_W];
         s1_mask_ff  <= req_tdata[INDEX_W + WORD_W +: WORD_W];
      end
      if (s2_load) begin
         s2_mask_count_ff <= mask_count_ff;
         s2_mismatch_ff   <= mismatch_in;
      end
      if (s2_advance) begin
         score_ff <= score_in;
      end
   end

   // query register file
   always_ff @(posedge clock) begin
      if (s1_query_write) begin
         query_sign_ff[s1_index_ff] <= s1_data_ff;
         query_mask_ff[s1_index_ff] <= s1_mask_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - SCORE_W){1'b0}}, score_ff};

   `MHRS_ASSERT_NEXT(a_accept_fills, clock, reset, req_accept, s1_valid_ff, "accepted request lost")
   `MHRS_ASSERT_NEXT(a_emit_moves, clock, reset, s2_load, s2_valid_ff, "row end did not reach score stage")
   `MHRS_ASSERT_NEXT(a_mask_restart, clock, reset, s1_query_write && (s1_index_ff == FIRST_INDEX), mask_count_ff == COUNT_W'($past(mask_pc)), "mask count restart wrong")
   `MHRS_ASSERT(a_score_range, clock, reset, !rsp_valid_ff || (($signed(score_ff) >= -SCORE_W'(2048)) && ($signed(score_ff) <= SCORE_W'(2048))) || (score_ff == SCORE_MAX[SCORE_W-1:0]), "score out of range")

endmodule

`default_nettype wire

FILE: tb/tb_masked_hamming_row_scorer.sv
// ----------------------------------------------------------------------------
// Masked Hamming row scorer testbench
// Loads ternary queries and streams 16-word rows through the request channel.
// A scoreboard keeps its own copy of the query and the running counts and
// predicts every row score, which is matched against the response channel.
// Covers the count and score saturation cases. Sender gaps and receiver
// stalls vary over four phases.
// ----------------------------------------------------------------------------

class hamming_score_board;
   logic [63:0]        sign_store [16];
   logic [63:0]        care_store [16];
   int                 care_bits;
   int                 miss_bits;
   logic signed [12:0] pending_scores [$];
   int                 errors;
   int                 query_words;
   int                 row_words;
   int                 scores_seen;

   function int clip_count(int v);
      return (v > int'(mhrs_pkg::COUNT_MAX)) ? int'(mhrs_pkg::COUNT_MAX) : v;
   endfunction

   function void flag(string msg);
      errors++;
      if (errors <= 10) begin
         $display("ERROR: %s", msg);
      end
   endfunction

   function void note_request(mhrs_pkg::kind_type kind, logic [3:0] idx,
                              logic [63:0] data, logic [63:0] mask);
      int score;
      if (kind == mhrs_pkg::KIND_QUERY) begin
         query_words++;
         sign_store[idx] = data;
         care_store[idx] = mask;
         care_bits = (idx == mhrs_pkg::FIRST_INDEX) ? $countones(mask)
                                                     : clip_count(care_bits + $countones(mask));
      end else begin
         row_words++;
         if (idx == mhrs_pkg::FIRST_INDEX) begin
            miss_bits = 0;
         end
         miss_bits = clip_count(miss_bits +
                                $countones((data ^ sign_store[idx]) & care_store[idx]));
         if (idx == mhrs_pkg::LAST_INDEX) begin
            score = 2 * care_bits - 4 * miss_bits;
            if (score < -2048) begin
               score = -2048;
            end
            if (score > 2048) begin
               score = 2048;
            end
            pending_scores.push_back(13'(score));
         end
      end
   endfunction

   function void check_score(logic [12:0] got);
      logic signed [12:0] want;
      scores_seen++;
      if (pending_scores.size() == 0) begin
         flag($sformatf("unexpected score %0d", $signed(got)));
      end else begin
         want = pending_scores.pop_front();
         if (got !== want) begin
            flag($sformatf("score: expected %0d, got %0d", want, $signed(got)));
         end
      end
   endfunction
endclass

module tb_masked_hamming_row_scorer;
   import mhrs_pkg::*;

   localparam int TOTAL_WORDS = 1700;
   localparam int PHASES      = 4;
   localparam int STALL_LIMIT = 5000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   hamming_score_board board;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int words_sent = 0;
   int quiet_cycles = 0;

   masked_hamming_row_scorer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // request and response monitor, plus watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            board.note_request(kind_type'(req_tuser), req_tdata[3:0],
                               req_tdata[67:4], req_tdata[131:68]);
         end
         if (rsp_tvalid && rsp_tready) begin
            board.check_score(rsp_tdata[SCORE_W-1:0]);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] care_pattern();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return rand64() & rand64();
         3: return rand64() | rand64();
         4: return 64'd1 << $urandom_range(63);
         default: return rand64();
      endcase
   endfunction

   task automatic send_word(kind_type kind, logic [3:0] idx, logic [63:0] data,
                            logic [63:0] mask);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, mask, data, idx};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      words_sent++;
   endtask

   task automatic load_query(bit dense);
      for (int i = 0; i < ROW_WORDS; i++) begin
         send_word(KIND_QUERY, 4'(i), rand64(), dense ? '1 : care_pattern());
      end
   endtask

   task automatic score_row();
      int          mode;
      logic [63:0] data;
      mode = $urandom_range(3);
      for (int i = 0; i < ROW_WORDS; i++) begin
         case (mode)
            0: data = board.sign_store[i] ^ (rand64() & rand64() & rand64());
            1: data = ~board.sign_store[i];
            default: data = rand64();
         endcase
         send_word(KIND_ROW, 4'(i), data, rand64());
      end
   endtask

   task automatic broken_row();
      int len;
      len = $urandom_range(1, 15);
      send_word(KIND_ROW, FIRST_INDEX, rand64(), rand64());
      for (int i = 1; i < len; i++) begin
         send_word(KIND_ROW, ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'(i),
                   rand64(), rand64());
      end
   endtask

   task automatic noise_burst();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         send_word(kind_type'($urandom_range(1)), 4'($urandom_range(15)), rand64(),
                   care_pattern());
      end
   endtask

   // care count runs past its limit, then a matching row clamps high
   task automatic saturate_care();
      for (int i = 0; i < 36; i++) begin
         send_word(KIND_QUERY, 4'($urandom_range(1, 15)), rand64(), '1);
      end
      for (int i = 0; i < ROW_WORDS; i++) begin
         send_word(KIND_ROW, 4'(i), board.sign_store[i], rand64());
      end
   endtask

   // mismatch total runs past its limit, score clamps low
   task automatic saturate_miss();
      logic [3:0] idx;
      load_query(1'b1);
      send_word(KIND_ROW, FIRST_INDEX, ~board.sign_store[0], rand64());
      for (int i = 0; i < 36; i++) begin
         idx = 4'($urandom_range(1, 14));
         send_word(KIND_ROW, idx, ~board.sign_store[idx], rand64());
      end
      send_word(KIND_ROW, LAST_INDEX, ~board.sign_store[LAST_INDEX], rand64());
   endtask

   initial begin
      int pick;
      board = new;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: only entries 0 and 15 are loaded here
      send_word(KIND_QUERY, FIRST_INDEX, '0, '1);
      send_word(KIND_QUERY, LAST_INDEX, '1, '1);
      send_word(KIND_ROW, FIRST_INDEX, '1, '0);
      send_word(KIND_ROW, LAST_INDEX, '0, '1);
      send_word(KIND_ROW, LAST_INDEX, '1, '0);
      send_word(KIND_ROW, FIRST_INDEX, '0, '1);
      send_word(KIND_ROW, LAST_INDEX, '1, '1);
      send_word(KIND_QUERY, FIRST_INDEX, '1, '0);
      send_word(KIND_QUERY, LAST_INDEX, '0, '0);
      send_word(KIND_ROW, FIRST_INDEX, '1, '1);
      send_word(KIND_ROW, LAST_INDEX, '1, '1);
      send_word(KIND_QUERY, LAST_INDEX, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      send_word(KIND_ROW, LAST_INDEX, 64'h5555_5555_5555_5555, '0);
      send_word(KIND_ROW, LAST_INDEX, 64'hAAAA_AAAA_AAAA_AAAA, '1);

      load_query(1'b0);
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         while (words_sent < (phase + 1) * TOTAL_WORDS / PHASES) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               score_row();
            end else if (pick < 70) begin
               load_query(1'b0);
            end else if (pick < 82) begin
               noise_burst();
            end else if (pick < 92) begin
               broken_row();
            end else if (pick < 96) begin
               saturate_care();
            end else begin
               saturate_miss();
            end
         end
      end
      req_tvalid <= 1'b0;

      while (board.pending_scores.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      $display("covered %0d requests: %0d query words, %0d row words",
               words_sent, board.query_words, board.row_words);
      $display("checked %0d scores, %0d mismatches", board.scores_seen, board.errors);
      if (board.errors == 0 && board.pending_scores.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
